// ===== rtl/kana_mora_splitter_assert.svh =====
// ----------------------------------------------------------------------------
// kana mora splitter assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef KANA_MORA_SPLITTER_ASSERT_SVH
`define KANA_MORA_SPLITTER_ASSERT_SVH

// same-cycle implication
`define KMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg
// shared types, constants and kana tables of the kana mora splitter
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] LONG_MARK = 21'h030FC;
  localparam logic [CP_W-1:0] HIRA_BASE = 21'h03040;
  localparam logic [CP_W-1:0] KATA_BASE = 21'h030A0;
  localparam logic [CP_W-1:0] BLOCK_LEN = 21'd96;

  // phase codes
  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_HELD  = 2'd1;
  localparam logic [1:0] PH_PAIR  = 2'd2;

  // vowel offsets inside a kana block
  localparam logic [6:0] VA = 7'h02;
  localparam logic [6:0] VI = 7'h04;
  localparam logic [6:0] VU = 7'h06;
  localparam logic [6:0] VE = 7'h08;
  localparam logic [6:0] VO = 7'h0A;
  localparam logic [6:0] VN = 7'h53;
  localparam logic [6:0] VX = 7'h00;

  // vowel offset for each kana offset, zero when none
  localparam logic [6:0] VOWEL_TAB [0:95] = '{
    VX, VX, VA, VX, VI, VX, VU, VX, VE, VX, VO, VA, VA, VI, VI, VU,
    VU, VE, VE, VO, VO, VA, VA, VI, VI, VU, VU, VE, VE, VO, VO, VA,
    VA, VI, VI, VX, VU, VU, VE, VE, VO, VO, VA, VI, VU, VE, VO, VA,
    VA, VA, VI, VI, VI, VU, VU, VU, VE, VE, VE, VO, VO, VO, VA, VI,
    VU, VE, VO, VX, VA, VX, VU, VX, VO, VA, VI, VU, VE, VO, VX, VA,
    VX, VX, VO, VN, VX, VX, VX, VX, VX, VX, VX, VX, VX, VX, VX, VX
  };

  // one result beat
  typedef struct packed {
    logic [CP_W-1:0] first_char;
    logic [CP_W-1:0] second_char;
    logic [1:0]      char_count;
    logic            from_long_mark;
    logic            last_of_word;
  } res_t;

  // step status toward the top level
  typedef struct packed {
    logic [1:0] phase;
  } step_stat_t;

  // queue status toward the top level
  typedef struct packed {
    logic [2:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/kms_classify.sv =====
// ----------------------------------------------------------------------------
// kms_classify
// small kana detection and vowel lookup for one code point
// ----------------------------------------------------------------------------
`default_nettype none

module kms_classify (
  input  wire logic [kms_pkg::CP_W-1:0] cp,
  output logic                          is_small,
  output logic [kms_pkg::CP_W-1:0]      vowel_cp
);

  logic [kms_pkg::CP_W-1:0] hira_d;
  logic [kms_pkg::CP_W-1:0] kata_d;
  logic                     in_hira;
  logic                     in_kata;
  logic [6:0]               off;
  logic [6:0]               vofs;
  logic [kms_pkg::CP_W-1:0] base;

  always_comb begin
    hira_d  = cp - kms_pkg::HIRA_BASE;
    kata_d  = cp - kms_pkg::KATA_BASE;
    in_hira = (cp >= kms_pkg::HIRA_BASE) && (hira_d < kms_pkg::BLOCK_LEN);
    in_kata = (cp >= kms_pkg::KATA_BASE) && (kata_d < kms_pkg::BLOCK_LEN);
    if (in_hira) begin
      off  = hira_d[6:0];
      base = kms_pkg::HIRA_BASE;
    end else begin
      off  = kata_d[6:0];
      base = kms_pkg::KATA_BASE;
    end
    // small a i u e o, small ya yu yo
    is_small = (in_hira || in_kata) &&
               (off == 7'h01 || off == 7'h03 || off == 7'h05 || off == 7'h07 ||
                off == 7'h09 || off == 7'h43 || off == 7'h45 || off == 7'h47);
    vofs = kms_pkg::VOWEL_TAB[off];
    if ((in_hira || in_kata) && vofs != kms_pkg::VX) begin
      vowel_cp = base + {14'd0, vofs};
    end else begin
      vowel_cp = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kms_step.sv =====
// ----------------------------------------------------------------------------
// kms_step
// lookahead state and result generation, up to two beats per accepted char
// ----------------------------------------------------------------------------
`default_nettype none

module kms_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take,
  input  wire logic [kms_pkg::CP_W-1:0]      code_point,
  input  wire logic                          word_end,
  output logic [1:0]                         n_res,
  output kms_pkg::res_t                      res0,
  output kms_pkg::res_t                      res1,
  output kms_pkg::step_stat_t                stat
);

  logic [1:0]               phase_r;
  logic [1:0]               phase_nxt;
  logic [kms_pkg::CP_W-1:0] held_r;
  logic [kms_pkg::CP_W-1:0] held_nxt;

  logic                     c_small;
  logic [kms_pkg::CP_W-1:0] h_vowel;
  logic                     c_mark;

  kms_classify u_cls_in (
    .cp       (code_point),
    .is_small (c_small),
    .vowel_cp ()
  );

  kms_classify u_cls_held (
    .cp       (held_r),
    .is_small (),
    .vowel_cp (h_vowel)
  );

  assign stat.phase = phase_r;

  always_comb begin
    c_mark    = (code_point == kms_pkg::LONG_MARK);
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (take) begin
      if (phase_r == kms_pkg::PH_HELD && c_small) begin
        res0      = '{held_r, code_point, 2'd2, 1'b0, word_end};
        n_res     = 2'd1;
        phase_nxt = kms_pkg::PH_PAIR;
        held_nxt  = '0;
      end else if (phase_r == kms_pkg::PH_HELD && c_mark) begin
        if (h_vowel != '0) begin
          res0  = '{held_r, '0, 2'd1, 1'b0, 1'b0};
          res1  = '{h_vowel, '0, 2'd1, 1'b1, word_end};
          n_res = 2'd2;
        end else begin
          res0  = '{held_r, '0, 2'd1, 1'b0, word_end};
          n_res = 2'd1;
        end
        phase_nxt = kms_pkg::PH_EMPTY;
        held_nxt  = '0;
      end else if (phase_r == kms_pkg::PH_HELD) begin
        res0      = '{held_r, '0, 2'd1, 1'b0, 1'b0};
        res1      = '{code_point, '0, 2'd1, 1'b0, 1'b1};
        n_res     = word_end ? 2'd2 : 2'd1;
        phase_nxt = kms_pkg::PH_HELD;
        held_nxt  = code_point;
      end else if (phase_r == kms_pkg::PH_PAIR && c_mark) begin
        // mark swallowed after a pair: empty end beat if the word stops here
        res0      = '{'0, '0, 2'd0, 1'b0, 1'b1};
        n_res     = word_end ? 2'd1 : 2'd0;
        phase_nxt = kms_pkg::PH_EMPTY;
        held_nxt  = '0;
      end else begin
        res0      = '{code_point, '0, 2'd1, 1'b0, 1'b1};
        n_res     = word_end ? 2'd1 : 2'd0;
        phase_nxt = kms_pkg::PH_HELD;
        held_nxt  = code_point;
      end
      if (word_end) begin
        phase_nxt = kms_pkg::PH_EMPTY;
        held_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kms_pkg::PH_EMPTY;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kms_outq.sv =====
// ----------------------------------------------------------------------------
// kms_outq
// four-entry result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kms_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [1:0]      n_push,
  input  wire kms_pkg::res_t   push0,
  input  wire kms_pkg::res_t   push1,
  input  wire logic            pop,
  output kms_pkg::res_t        head,
  output logic                 head_valid,
  output logic                 room,
  output kms_pkg::q_stat_t     stat
);

  kms_pkg::res_t ent_r   [0:3];
  kms_pkg::res_t ent_nxt [0:3];
  logic [2:0]    cnt_r;
  logic [2:0]    cnt_nxt;
  logic [2:0]    base;

  assign head       = ent_r[0];
  assign head_valid = (cnt_r != 3'd0);
  assign room       = (cnt_r < 3'd3);
  assign stat.count = cnt_r;

  always_comb begin
    base = cnt_r - {2'd0, pop};
    for (int i = 0; i < 4; i++) begin
      if (pop && i < 3) begin
        ent_nxt[i] = ent_r[(i < 3) ? i + 1 : i];
      end else begin
        ent_nxt[i] = ent_r[i];
      end
      if (n_push != 2'd0 && base == 3'(i)) begin
        ent_nxt[i] = push0;
      end
      if (n_push == 2'd2 && base + 3'd1 == 3'(i)) begin
        ent_nxt[i] = push1;
      end
    end
    cnt_nxt = base + {1'b0, n_push};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kana_mora_splitter.sv =====
// ----------------------------------------------------------------------------
// kana_mora_splitter
// splits a stream of code points into morae with long-mark vowel expansion
// ----------------------------------------------------------------------------
// One code point enters per beat, the word's last one flagged by in_tlast.
// A character is held as lookahead for the next beat: a following small kana
// joins it into a two-character mora, a following long mark (U+30FC) is
// consumed and, for a single kana with a known vowel, becomes a vowel mora
// flagged in out_tuser. Each input beat yields zero, one or two result beats,
// computed combinationally and written into a four-entry result queue. The
// input takes a beat every cycle while the queue holds fewer than three
// entries, so one character per cycle is sustained whenever the downstream
// side takes one beat per cycle; a beat that expands to two results needs
// two output beats. Results reach the output through the registered queue.
// A word whose final mark follows a pair ends with an empty beat
// (char_count zero) marked last.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kana_mora_splitter_assert.svh"

module kana_mora_splitter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [20:0] code_point, rest zero
  input  wire logic        in_tlast,   // word_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [20:0] first_char, [41:21] second_char,
                                       // [43:42] char_count, rest zero
  output logic [0:0]       out_tuser,  // [0] from_long_mark
  output logic             out_tlast   // last_of_word
);

  logic                  in_fire;
  logic                  out_fire;
  logic [1:0]            n_res;
  kms_pkg::res_t         res0;
  kms_pkg::res_t         res1;
  kms_pkg::res_t         head;
  logic                  room;
  kms_pkg::step_stat_t   st_step;
  kms_pkg::q_stat_t      st_q;

  // handshakes
  assign in_tready = room;
  assign in_fire   = in_tvalid && room;
  assign out_fire  = out_tvalid && out_tready;

  // lookahead state and per-character result generation
  kms_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_fire),
    .code_point (in_tdata[20:0]),
    .word_end   (in_tlast),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1),
    .stat       (st_step)
  );

  // result queue decouples the two sides
  kms_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_push     (n_res),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_fire),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room),
    .stat       (st_q)
  );

  // pack the head beat
  assign out_tdata = {4'd0, head.char_count, head.second_char, head.first_char};
  assign out_tuser = head.from_long_mark;
  assign out_tlast = head.last_of_word;

  // checks
  `KMS_ASSERT_SAME(a_q_bound, 1'b1, st_q.count <= 3'd4, "result queue overflow")
  `KMS_ASSERT_NEXT(a_end_clears, in_fire && in_tlast, st_step.phase == kms_pkg::PH_EMPTY,
                   "phase not empty after word end")
  `KMS_ASSERT_SAME(a_empty_last, out_tvalid && out_tdata[43:42] == 2'd0, out_tlast,
                   "empty beat not marked last")
  `KMS_ASSERT_NEXT(a_pop_only, out_fire && !in_fire,
                   st_q.count == $past(st_q.count) - 3'd1,
                   "queue count did not drop on pop")

endmodule

`default_nettype wire

// ===== sim/tb_kana_mora_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_kana_mora_splitter
// self-checking bench: words of code points go in, morae are predicted
// in the bench and compared beat by beat with the result stream, under
// random gaps on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb_kana_mora_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1400;

  // vowel offset inside a kana block, by kana offset
  localparam logic [6:0] K_X = 7'h00;
  localparam logic [6:0] K_A = 7'h02;
  localparam logic [6:0] K_I = 7'h04;
  localparam logic [6:0] K_U = 7'h06;
  localparam logic [6:0] K_E = 7'h08;
  localparam logic [6:0] K_O = 7'h0A;
  localparam logic [6:0] K_N = 7'h53;

  logic [6:0] vowel_ofs [0:95] = '{
    K_X, K_X, K_A, K_X, K_I, K_X, K_U, K_X, K_E, K_X, K_O, K_A, K_A, K_I, K_I, K_U,
    K_U, K_E, K_E, K_O, K_O, K_A, K_A, K_I, K_I, K_U, K_U, K_E, K_E, K_O, K_O, K_A,
    K_A, K_I, K_I, K_X, K_U, K_U, K_E, K_E, K_O, K_O, K_A, K_I, K_U, K_E, K_O, K_A,
    K_A, K_A, K_I, K_I, K_I, K_U, K_U, K_U, K_E, K_E, K_E, K_O, K_O, K_O, K_A, K_I,
    K_U, K_E, K_O, K_X, K_A, K_X, K_U, K_X, K_O, K_A, K_I, K_U, K_E, K_O, K_X, K_A,
    K_X, K_X, K_O, K_N, K_X, K_X, K_X, K_X, K_X, K_X, K_X, K_X, K_X, K_X, K_X, K_X
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [20:0] code_point, rest zero
  logic        in_tlast = 1'b0;  // word_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [20:0] first_char, [41:21] second_char,
                                 // [43:42] char_count, rest zero
  logic [0:0]  out_tuser;        // [0] from_long_mark
  logic        out_tlast;        // last_of_word

  kana_mora_splitter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // predictor state: phase and the character held as lookahead
  logic [1:0]      mora_phase = kms_pkg::PH_EMPTY;
  logic [20:0]     held_cp = '0;
  kms_pkg::res_t   expected_morae [$];

  int unsigned     mismatch_count = 0;
  int unsigned     items_sent = 0;
  int unsigned     cycle_count = 0;
  bit              no_idle = 1'b0;   // both sides run without gaps
  bit              hold_req = 1'b0;  // ask the receiver for a long stall

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly zero, sometimes a few cycles, rarely a long stretch
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start of the kana block holding cp, zero when cp is outside both
  function automatic logic [20:0] kana_block(input logic [20:0] cp);
    if (cp >= kms_pkg::HIRA_BASE && cp < kms_pkg::HIRA_BASE + kms_pkg::BLOCK_LEN)
      return kms_pkg::HIRA_BASE;
    if (cp >= kms_pkg::KATA_BASE && cp < kms_pkg::KATA_BASE + kms_pkg::BLOCK_LEN)
      return kms_pkg::KATA_BASE;
    return '0;
  endfunction

  // small a, i, u, e, o, ya, yu, yo of either script
  function automatic bit is_small_kana(input logic [20:0] cp);
    logic [20:0] base;
    logic [20:0] off;
    base = kana_block(cp);
    off  = cp - base;
    if (base == '0) return 1'b0;
    case (off)
      21'h01, 21'h03, 21'h05, 21'h07, 21'h09, 21'h43, 21'h45, 21'h47: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // vowel that a long mark stands for after cp, zero if none
  function automatic logic [20:0] vowel_for(input logic [20:0] cp);
    logic [20:0] base;
    logic [20:0] off;
    base = kana_block(cp);
    off  = cp - base;
    if (base == '0 || vowel_ofs[off[6:0]] == K_X) return '0;
    return base + {14'd0, vowel_ofs[off[6:0]]};
  endfunction

  task automatic add_mora(input logic [20:0] first, input logic [20:0] second,
                          input logic [1:0] count, input logic vowel, input logic last);
    kms_pkg::res_t m;
    m.first_char     = first;
    m.second_char    = second;
    m.char_count     = count;
    m.from_long_mark = vowel;
    m.last_of_word   = last;
    expected_morae.insert(expected_morae.size(), m);
  endtask

  // next state and the morae caused by one accepted character
  task automatic predict_morae(input logic [20:0] cp, input logic fin);
    logic [20:0] vow;
    if (mora_phase == kms_pkg::PH_HELD) begin
      if (is_small_kana(cp)) begin
        add_mora(held_cp, cp, 2'd2, 1'b0, fin);
        mora_phase = kms_pkg::PH_PAIR;
        held_cp    = '0;
      end else if (cp == kms_pkg::LONG_MARK) begin
        vow = vowel_for(held_cp);
        if (vow != '0) begin
          add_mora(held_cp, '0, 2'd1, 1'b0, 1'b0);
          add_mora(vow, '0, 2'd1, 1'b1, fin);
        end else begin
          add_mora(held_cp, '0, 2'd1, 1'b0, fin);
        end
        mora_phase = kms_pkg::PH_EMPTY;
        held_cp    = '0;
      end else begin
        add_mora(held_cp, '0, 2'd1, 1'b0, 1'b0);
        held_cp    = cp;
        mora_phase = kms_pkg::PH_HELD;
        if (fin) add_mora(cp, '0, 2'd1, 1'b0, 1'b1);
      end
    end else if (mora_phase == kms_pkg::PH_PAIR && cp == kms_pkg::LONG_MARK) begin
      // mark swallowed after a pair, an empty beat closes the word
      mora_phase = kms_pkg::PH_EMPTY;
      held_cp    = '0;
      if (fin) add_mora('0, '0, 2'd0, 1'b0, 1'b1);
    end else begin
      held_cp    = cp;
      mora_phase = kms_pkg::PH_HELD;
      if (fin) add_mora(cp, '0, 2'd1, 1'b0, 1'b1);
    end
    if (fin) begin
      mora_phase = kms_pkg::PH_EMPTY;
      held_cp    = '0;
    end
  endtask

  // offer one character, wait for the beat to be taken, then predict
  task automatic send_char(input logic [20:0] cp, input logic fin);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, cp};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_morae(cp, fin);
  endtask

  task automatic send_word(input logic [20:0] chars [$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // character mix that mostly forms real kana words
  function automatic logic [20:0] pick_char();
    logic [20:0] base;
    int unsigned r;
    base = $urandom_range(0, 1) ? kms_pkg::HIRA_BASE : kms_pkg::KATA_BASE;
    r = $urandom_range(0, 99);
    if (r < 45) return base + 21'($urandom_range(0, 95));
    if (r < 60) begin
      case ($urandom_range(0, 7))
        0: return base + 21'h01;
        1: return base + 21'h03;
        2: return base + 21'h05;
        3: return base + 21'h07;
        4: return base + 21'h09;
        5: return base + 21'h43;
        6: return base + 21'h45;
        default: return base + 21'h47;
      endcase
    end
    if (r < 75) return kms_pkg::LONG_MARK;
    if (r < 90) return 21'($urandom_range(0, 1114111));
    return 21'($urandom_range(21'h03030, 21'h0310F));
  endfunction

  task automatic send_random_word();
    logic [20:0] chars [$];
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
    repeat (len) chars.insert(chars.size(), pick_char());
    send_word(chars);
  endtask

  // ---- test tasks ----

  // plain characters, extremes of the code point, pairs
  task automatic test_single_and_pairs();
    send_word('{21'h000000, 21'h10FFFF});   // held char followed by ordinary one
    send_word('{21'h0304B, 21'h03083});     // ka + small ya
    send_word('{21'h03041, 21'h030E7});     // small kana at a mora start, then pair
  endtask

  // long mark after vowel kana, syllabic n, non-kana, pairs and itself
  task automatic test_long_marks();
    send_word('{21'h0304B, kms_pkg::LONG_MARK});          // hiragana vowel
    send_word('{21'h030F3, kms_pkg::LONG_MARK});          // katakana n repeats itself
    send_word('{21'h00041, kms_pkg::LONG_MARK});          // no vowel known
    send_word('{kms_pkg::LONG_MARK, kms_pkg::LONG_MARK}); // mark at a mora start
    send_word('{21'h030AD, 21'h030E5, kms_pkg::LONG_MARK});  // empty end beat
    send_word('{21'h030B7, 21'h030E7, kms_pkg::LONG_MARK, 21'h030C8});
  endtask

  // the code before hiragana, its last offset, the first katakana offset and the code after it
  task automatic test_block_edges();
    send_word('{21'h0303F, kms_pkg::LONG_MARK});
    send_word('{21'h0309F, kms_pkg::LONG_MARK});
    send_word('{21'h030A0, 21'h03100});
  endtask

  // no gaps on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    while (items_sent < 90) send_random_word();
    no_idle = 1'b0;
  endtask

  // receiver stalls for a long stretch while words keep coming
  task automatic test_output_stall();
    int unsigned start;
    start    = items_sent;
    no_idle  = 1'b1;
    hold_req = 1'b1;
    while (items_sent < start + 40) begin
      send_word('{21'h0304B, kms_pkg::LONG_MARK, 21'h030AD, 21'h030E5});
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_words();
    int unsigned start;
    start = items_sent;
    while (items_sent < start + RANDOM_ITEMS) send_random_word();
  endtask

  // ---- receiver ready, with its own stall counter ----
  initial begin : rx_ready
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = idle_cycles();
      end
    end
  end

  // ---- result check, oldest expectation first ----
  always @(posedge clk) begin : mora_check
    kms_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_morae.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        want = expected_morae.pop_front();
        if (out_tdata[20:0] !== want.first_char) begin
          $error("first_char: expected %h, got %h", want.first_char, out_tdata[20:0]);
          mismatch_count++;
        end
        if (out_tdata[41:21] !== want.second_char) begin
          $error("second_char: expected %h, got %h", want.second_char, out_tdata[41:21]);
          mismatch_count++;
        end
        if (out_tdata[43:42] !== want.char_count) begin
          $error("char_count: expected %0d, got %0d", want.char_count, out_tdata[43:42]);
          mismatch_count++;
        end
        if (out_tuser[0] !== want.from_long_mark) begin
          $error("from_long_mark: expected %b, got %b", want.from_long_mark, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tlast !== want.last_of_word) begin
          $error("last_of_word: expected %b, got %b", want.last_of_word, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---- test sequence ----
  initial begin : run_tests
    int unsigned waited;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_single_and_pairs();
    test_long_marks();
    test_block_edges();
    test_back_to_back();
    test_output_stall();
    test_random_words();
    in_tvalid <= 1'b0;

    // drain, then wait on for any stray beat
    waited = 0;
    while (expected_morae.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_morae.size() != 0) begin
      $error("%0d expected morae never arrived", expected_morae.size());
      mismatch_count++;
    end
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
